// File: src/sjrf_pkg.sv
// ----------------------------------------------------------------------------
// Shift-JIS run finder package
// Shared constants, result types and byte classification functions.
// ----------------------------------------------------------------------------
package sjrf_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int FIFO_DEPTH      = 4;
  localparam logic [15:0] MIN_LENGTH_RST = 16'd4;
  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

  // Register index of min_length on the APB port.
  localparam logic REG_MIN_LENGTH = 1'b0;

  typedef struct packed {
    logic [31:0] start_offset;
    logic [31:0] run_length;
    logic        final_result;
  } result_t;

  // Results produced by one byte, zero to two of them.
  typedef struct packed {
    logic [1:0]       num;
    result_t [1:0]    res;
  } push_t;

  function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic single_ok(input logic [7:0] b);
    return in_range(b, 8'h20, 8'h7d) || in_range(b, 8'ha1, 8'hdf);
  endfunction

  function automatic logic lead_ok(input logic [7:0] b);
    return in_range(b, 8'h81, 8'h84) || in_range(b, 8'h88, 8'h9f) ||
           in_range(b, 8'he0, 8'hea);
  endfunction

  function automatic logic trail_ok(input logic [7:0] lead, input logic [7:0] t);
    logic ok;
    ok = 1'b0;
    case (lead)
      8'h81: ok = in_range(t, 8'h40, 8'hac) || in_range(t, 8'hb8, 8'hbf) ||
                  in_range(t, 8'hc8, 8'hce) || in_range(t, 8'hda, 8'he8) ||
                  in_range(t, 8'hf0, 8'hf7) || (t == 8'hfc);
      8'h82: ok = in_range(t, 8'h4f, 8'h58) || in_range(t, 8'h60, 8'h79) ||
                  in_range(t, 8'h81, 8'h9a) || in_range(t, 8'h9f, 8'hf1);
      8'h83: ok = in_range(t, 8'h40, 8'h96) || in_range(t, 8'h9f, 8'hb6) ||
                  in_range(t, 8'hbf, 8'hd6);
      8'h84: ok = in_range(t, 8'h40, 8'h60) || in_range(t, 8'h70, 8'h91) ||
                  in_range(t, 8'h9f, 8'hbe);
      8'h88: ok = in_range(t, 8'h9f, 8'hfc);
      8'h98: ok = in_range(t, 8'h40, 8'h72) || in_range(t, 8'h9f, 8'hfc);
      8'hea: ok = in_range(t, 8'h40, 8'ha4);
      default: begin
        if (in_range(lead, 8'h89, 8'h97) || in_range(lead, 8'h99, 8'he9)) begin
          ok = in_range(t, 8'h40, 8'hfc);
        end
      end
    endcase
    return ok;
  endfunction

  // Saturating add of a one- or two-byte step to the run length.
  function automatic logic [31:0] sat_add(input logic [31:0] c, input logic [1:0] n);
    logic [32:0] s;
    s = {1'b0, c} + {31'b0, n};
    return s[32] ? LEN_MAX : s[31:0];
  endfunction

endpackage

// File: src/sjrf_in_if.sv
// ----------------------------------------------------------------------------
// Shift-JIS run finder byte channel
// Valid/ready channel carrying one stream byte and its end-of-stream flag.
// ----------------------------------------------------------------------------
interface sjrf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

// File: src/sjrf_out_if.sv
// ----------------------------------------------------------------------------
// Shift-JIS run finder result channel
// Valid/ready channel carrying one reported run.
// ----------------------------------------------------------------------------
interface sjrf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] start_offset;
  logic [31:0] run_length;
  logic        final_result;

  modport source (output valid, output start_offset, output run_length,
                  output final_result, input ready);
  modport sink   (input valid, input start_offset, input run_length,
                  input final_result, output ready);
endinterface

// File: src/sjrf_scan.sv
// ----------------------------------------------------------------------------
// Shift-JIS run finder scanner
// Input register, run state and the per-byte classification and run update.
// ----------------------------------------------------------------------------
module sjrf_scan #(
  parameter int OFFSET_BITS = sjrf_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sjrf_in_if.sink           byte_i,
  input  logic [15:0]       min_length_i,
  input  logic              room_i,
  output sjrf_pkg::push_t   push_o
);

  logic                   in_valid_q;
  logic [7:0]             byte_q;
  logic                   eos_q;
  logic                   go;

  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] beg_q, beg_d;
  logic [31:0]            cnt_q, cnt_d;
  logic [7:0]             lead_q, lead_d;
  logic                   pend_q, pend_d;
  logic                   inside_q, inside_d;

  logic [1:0]             nres;
  sjrf_pkg::result_t [1:0] res;
  logic [31:0]            min_ext;

  assign go           = in_valid_q && room_i;
  assign byte_i.ready = !in_valid_q || room_i;
  assign min_ext      = {16'b0, min_length_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.valid && byte_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.data_byte;
      eos_q  <= byte_i.end_of_stream;
    end
  end

  // A failed trail closes the run before the lead, then the same byte is
  // examined again, so one byte can close a run and also open one that the
  // end of stream closes at once.
  always_comb begin
    pos_d    = pos_q;
    beg_d    = beg_q;
    cnt_d    = cnt_q;
    lead_d   = lead_q;
    pend_d   = pend_q;
    inside_d = inside_q;
    nres     = 2'd0;
    res      = '0;
    if (go) begin
      if (pend_q && sjrf_pkg::trail_ok(lead_q, byte_q)) begin
        pend_d   = 1'b0;
        lead_d   = 8'h00;
        cnt_d    = sjrf_pkg::sat_add(cnt_d, 2'd2);
        inside_d = 1'b1;
      end else begin
        if (pend_q) begin
          pend_d = 1'b0;
          lead_d = 8'h00;
          if (inside_d && (cnt_d >= min_ext) && (nres != 2'd2)) begin
            res[nres[0]] = '{start_offset: 32'(beg_d), run_length: cnt_d,
                             final_result: 1'b0};
            nres = nres + 2'd1;
          end
          inside_d = 1'b0;
          cnt_d    = '0;
          beg_d    = '0;
        end
        if (sjrf_pkg::single_ok(byte_q)) begin
          if (!inside_d) begin
            beg_d = pos_q;
          end
          cnt_d    = sjrf_pkg::sat_add(cnt_d, 2'd1);
          inside_d = 1'b1;
        end else if (sjrf_pkg::lead_ok(byte_q)) begin
          if (!inside_d) begin
            beg_d = pos_q;
          end
          lead_d = byte_q;
          pend_d = 1'b1;
        end else begin
          if (inside_d && (cnt_d >= min_ext) && (nres != 2'd2)) begin
            res[nres[0]] = '{start_offset: 32'(beg_d), run_length: cnt_d,
                             final_result: 1'b0};
            nres = nres + 2'd1;
          end
          inside_d = 1'b0;
          cnt_d    = '0;
          beg_d    = '0;
        end
      end
      if (eos_q) begin
        pend_d = 1'b0;
        lead_d = 8'h00;
        if (inside_d && (cnt_d >= min_ext) && (nres != 2'd2)) begin
          res[nres[0]] = '{start_offset: 32'(beg_d), run_length: cnt_d,
                           final_result: 1'b0};
          nres = nres + 2'd1;
        end
        inside_d = 1'b0;
        cnt_d    = '0;
        beg_d    = '0;
        pos_d    = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
      if (nres != 2'd0) begin
        res[1'(nres - 2'd1)].final_result = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      beg_q    <= '0;
      cnt_q    <= '0;
      lead_q   <= '0;
      pend_q   <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      beg_q    <= beg_d;
      cnt_q    <= cnt_d;
      lead_q   <= lead_d;
      pend_q   <= pend_d;
      inside_q <= inside_d;
    end
  end

  assign push_o.num = nres;
  assign push_o.res = res;

endmodule

// File: src/sjrf_res_fifo.sv
// ----------------------------------------------------------------------------
// Shift-JIS run finder result queue
// Small queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module sjrf_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sjrf_pkg::push_t push_i,
  output logic            room_o,
  sjrf_out_if.source      run_o
);

  localparam int Depth = sjrf_pkg::FIFO_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  sjrf_pkg::result_t mem [Depth];
  logic [PtrW-1:0] wp_q, rp_q, wp_nx;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign wp_nx  = wp_q + 1'b1;
  assign pop    = run_o.valid && run_o.ready;
  // Room for the worst case of two results from the next byte.
  assign room_o = count_q <= CntW'(Depth - 2);

  assign run_o.valid        = count_q != '0;
  assign run_o.start_offset = mem[rp_q].start_offset;
  assign run_o.run_length   = mem[rp_q].run_length;
  assign run_o.final_result = mem[rp_q].final_result;

  assign count_d = count_q + CntW'(push_i.num) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem[wp_q] <= push_i.res[0];
    end
    if (push_i.num == 2'd2) begin
      mem[wp_nx] <= push_i.res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_q + PtrW'(push_i.num);
      rp_q    <= rp_q + PtrW'(pop);
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW'(push_i.num) <= CntW'(Depth) - count_q))
    else $error("result queue overflow");

  a_num_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd3)
    else $error("more than two results from one byte");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (push_i.num == 2'd0) && (count_q == CntW'(1))) |=> !run_o.valid)
    else $error("queue still valid after last entry left");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num == 2'd2) |-> (!push_i.res[0].final_result && push_i.res[1].final_result))
    else $error("final flag not on last of two results");

endmodule

// File: src/shift_jis_run_finder.sv
// ----------------------------------------------------------------------------
// Shift-JIS run finder
// Scans a byte stream and reports runs of valid Shift-JIS text.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle on byte_i and reports each run of
// valid Shift-JIS text that reaches min_length bytes as its start offset and
// length on run_o. A byte is registered on transfer and classified and folded
// into the run state once the result queue has room; its results enter a
// four-entry queue whose head drives run_o. A byte produces at most two
// results and the queue hands out one per cycle while run_o is ready; byte_i
// keeps taking a byte every cycle while the queue holds two results or fewer.
// Offsets count from zero at the start of each stream and restart after a
// byte flagged end_of_stream. min_length is written over APB at address 0.
module shift_jis_run_finder #(
  parameter int OFFSET_BITS = sjrf_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sjrf_in_if.sink     byte_i,
  sjrf_out_if.source  run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]     min_length_q;
  logic            room;
  sjrf_pkg::push_t push;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= sjrf_pkg::MIN_LENGTH_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == sjrf_pkg::REG_MIN_LENGTH)) begin
      min_length_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == sjrf_pkg::REG_MIN_LENGTH) ? {16'b0, min_length_q} : '0;

  sjrf_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .min_length_i (min_length_q),
    .room_i       (room),
    .push_o       (push)
  );

  sjrf_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .run_o  (run_o)
  );

endmodule
